/* rtl/tlqc_pkg.sv */
package tlqc_pkg;

  localparam int COORD_W  = 24;
  localparam int WIDTH_W  = 20;
  localparam int DIFF_W   = COORD_W + 2;
  localparam int MAG_W    = COORD_W + 1;
  localparam int SHIFT_W  = 5;
  localparam int NORM_BIT = 29;
  localparam int XY_W     = NORM_BIT + 5;
  localparam int GAIN_W   = 24;
  localparam int PROD_W   = WIDTH_W + GAIN_W;
  localparam int OFS_W    = WIDTH_W + 3;
  localparam int SUM_W    = COORD_W + 2;

  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int FRACTION_BITS_DEF = 8;

  // Reciprocal of the CORDIC gain in Q.24.
  localparam logic [GAIN_W-1:0] INV_GAIN_Q24 = GAIN_W'(10188014);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [WIDTH_W-1:0] lwidth_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    coord_t  sx;
    coord_t  sy;
    coord_t  ex;
    coord_t  ey;
    lwidth_t w;
    logic    zero;
  } carry_t;

  function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
    coord_t r;
    if (v > SUM_W'(COORD_MAX)) begin
      r = COORD_MAX;
    end else if (v < SUM_W'(COORD_MIN)) begin
      r = COORD_MIN;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/thick_line_quad_corners.sv */
// Thick-line quad corners: turns a line segment and a thickness into the four
// corners of the quad that extrudes it.
//
// Input channel: a beat is taken at each rising edge with start high and busy
// low. busy is held low, so a new segment may enter in every cycle.
// Output channel: done is high for exactly one cycle with the eight corner
// coordinates; the receiver must take the beat in that cycle.
//
// Throughput is one beat per cycle. The pipeline stages, in order: difference,
// normalise search with the gain multiply, shift, one register stage per CORDIC
// step, offset rounding and the saturating corner adders.
//
// Reset clears every stage valid bit, so no beat in flight survives it; the
// datapath registers are not reset. There is no back-pressure from the
// receiver.
module thick_line_quad_corners #(
  parameter int CORDIC_STEPS  = tlqc_pkg::CORDIC_STEPS_DEF,
  parameter int FRACTION_BITS = tlqc_pkg::FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tlqc_pkg::coord_t start_x,
  input  tlqc_pkg::coord_t start_y,
  input  tlqc_pkg::coord_t end_x,
  input  tlqc_pkg::coord_t end_y,
  input  tlqc_pkg::lwidth_t line_width,
  output logic             done,
  output tlqc_pkg::coord_t corner0_x,
  output tlqc_pkg::coord_t corner0_y,
  output tlqc_pkg::coord_t corner1_x,
  output tlqc_pkg::coord_t corner1_y,
  output tlqc_pkg::coord_t corner2_x,
  output tlqc_pkg::coord_t corner2_y,
  output tlqc_pkg::coord_t corner3_x,
  output tlqc_pkg::coord_t corner3_y
);
  import tlqc_pkg::*;

  localparam int UV_W     = OFS_W + FRACTION_BITS - 1;
  localparam int PRE_SH   = GAIN_W - (FRACTION_BITS - 1);
  localparam logic [PROD_W:0] GAIN_RND = (PROD_W+1)'(1) << (PRE_SH - 1);
  localparam logic signed [UV_W-1:0] OFS_RND = UV_W'(1) << (FRACTION_BITS - 1);

  assign busy = 1'b0;

  // Stage 1: differences, folded so that dx is non-negative.
  logic                     s1_vld;
  carry_t                   s1_c;
  logic signed [DIFF_W-1:0] s1_dx, s1_dy;
  logic signed [DIFF_W-1:0] dx_raw, dy_raw;

  always_comb begin
    dx_raw = DIFF_W'(end_x) - DIFF_W'(start_x);
    dy_raw = DIFF_W'(end_y) - DIFF_W'(start_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start;
    end
    s1_c.sx   <= start_x;
    s1_c.sy   <= start_y;
    s1_c.ex   <= end_x;
    s1_c.ey   <= end_y;
    s1_c.w    <= line_width;
    s1_c.zero <= (dx_raw == '0) && (dy_raw == '0);
    if (dx_raw < 0) begin
      s1_dx <= -dx_raw;
      s1_dy <= -dy_raw;
    end else begin
      s1_dx <= dx_raw;
      s1_dy <= dy_raw;
    end
  end

  // Stage 2: normalise shift search and the gain multiply.
  logic                     s2_vld;
  carry_t                   s2_c;
  logic signed [DIFF_W-1:0] s2_dx, s2_dy;
  logic [SHIFT_W-1:0]       s2_sh;
  logic [PROD_W-1:0]        s2_prod;
  logic [MAG_W-1:0]         ady, mag;
  logic [SHIFT_W-1:0]       sh_next;

  always_comb begin
    ady = (s1_dy < 0) ? MAG_W'(-s1_dy) : MAG_W'(s1_dy);
    mag = (MAG_W'(s1_dx) > ady) ? MAG_W'(s1_dx) : ady;
    sh_next = '0;
    // The highest set bit wins.
    for (int j = 0; j < MAG_W; j++) begin
      if (mag[j]) begin
        sh_next = SHIFT_W'(NORM_BIT - j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_c    <= s1_c;
    s2_dx   <= s1_dx;
    s2_dy   <= s1_dy;
    s2_sh   <= sh_next;
    s2_prod <= PROD_W'(s1_c.w) * PROD_W'(INV_GAIN_Q24);
  end

  // Stage 3: apply the shift and round the scaled half width.
  logic                   cv [0:CORDIC_STEPS];
  carry_t                 cc [0:CORDIC_STEPS];
  logic signed [XY_W-1:0] cx [0:CORDIC_STEPS];
  logic signed [XY_W-1:0] cy [0:CORDIC_STEPS];
  logic signed [UV_W-1:0] cu [0:CORDIC_STEPS];
  logic signed [UV_W-1:0] cw [0:CORDIC_STEPS];
  logic [PROD_W:0]        u_sum;

  assign u_sum = (PROD_W+1)'(s2_prod) + GAIN_RND;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= s2_vld;
    end
    cc[0] <= s2_c;
    cx[0] <= XY_W'(s2_dx) <<< s2_sh;
    cy[0] <= XY_W'(s2_dy) <<< s2_sh;
    cu[0] <= UV_W'(u_sum >> PRE_SH);
    cw[0] <= '0;
  end

  // One register stage per CORDIC step. The vectoring pair steers the
  // rotation of the offset vector through the same angle.
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k+1] <= 1'b0;
      end else begin
        cv[k+1] <= cv[k];
      end
      cc[k+1] <= cc[k];
      if (cy[k] >= 0) begin
        cx[k+1] <= cx[k] + (cy[k] >>> k);
        cy[k+1] <= cy[k] - (cx[k] >>> k);
        cu[k+1] <= cu[k] - (cw[k] >>> k);
        cw[k+1] <= cw[k] + (cu[k] >>> k);
      end else begin
        cx[k+1] <= cx[k] - (cy[k] >>> k);
        cy[k+1] <= cy[k] + (cx[k] >>> k);
        cu[k+1] <= cu[k] + (cw[k] >>> k);
        cw[k+1] <= cw[k] - (cu[k] >>> k);
      end
    end
  end

  // Round the Q.8 offset to an integer; a zero-length segment takes the half width.
  logic                    r_vld;
  carry_t                  r_c;
  logic signed [OFS_W-1:0] r_ox, r_oy;
  logic signed [UV_W-1:0]  ox_full, oy_full;
  logic [WIDTH_W:0]        half_w;

  always_comb begin
    ox_full = (cw[CORDIC_STEPS] + OFS_RND) >>> FRACTION_BITS;
    oy_full = (cu[CORDIC_STEPS] + OFS_RND) >>> FRACTION_BITS;
    half_w  = ((WIDTH_W+1)'(cc[CORDIC_STEPS].w) + (WIDTH_W+1)'(1)) >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else begin
      r_vld <= cv[CORDIC_STEPS];
    end
    r_c <= cc[CORDIC_STEPS];
    if (cc[CORDIC_STEPS].zero) begin
      r_ox <= OFS_W'(half_w);
      r_oy <= OFS_W'(half_w);
    end else begin
      r_ox <= ox_full[OFS_W-1:0];
      r_oy <= oy_full[OFS_W-1:0];
    end
  end

  // Corner adders with saturation.
  logic signed [SUM_W-1:0] ex_ox, ey_oy;
  logic signed [SUM_W-1:0] sx_w, sy_w, ex_w, ey_w;

  always_comb begin
    ex_ox = SUM_W'(r_ox);
    ey_oy = SUM_W'(r_oy);
    sx_w  = SUM_W'($signed(r_c.sx));
    sy_w  = SUM_W'($signed(r_c.sy));
    ex_w  = SUM_W'($signed(r_c.ex));
    ey_w  = SUM_W'($signed(r_c.ey));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= r_vld;
    end
    corner0_x <= sat_coord(sx_w - ex_ox);
    corner0_y <= sat_coord(sy_w + ey_oy);
    corner1_x <= sat_coord(ex_w - ex_ox);
    corner1_y <= sat_coord(ey_w + ey_oy);
    corner2_x <= sat_coord(ex_w + ex_ox);
    corner2_y <= sat_coord(ey_w - ey_oy);
    corner3_x <= sat_coord(sx_w + ex_ox);
    corner3_y <= sat_coord(sy_w - ey_oy);
  end

endmodule
